// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the deque block.
// Needs nothing else; each macro takes a label, a clock, an active-low reset
// and the two sides of the implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/deq_pkg.sv -----
// Types and constants of the double-ended queue.
// Used by the cell, the top level and the checker; depends on nothing.
`default_nettype none

package deq_pkg;

    localparam int WORD_W    = 32;
    localparam int ACTION_W  = 2;
    localparam int CNT_OUT_W = 5;
    // Result word: popped, underflow, overflow, front, back, count, empty.
    localparam int RESULT_W  = 3 * WORD_W + 3 + CNT_OUT_W;
    localparam int RESULT_PAD_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_BACK   = 2'd2,
        ACT_POP_FRONT  = 2'd3
    } t_action;

    // Commands broadcast to every cell. The f lane keeps the front word in
    // cell 0, the b lane keeps the back word in cell 0.
    typedef struct packed {
        logic f_shr;
        logic f_shl;
        logic f_wr;
        logic b_shr;
        logic b_shl;
        logic b_wr;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- rtl/deq_cell.sv -----
// One cell of the deque chain: a word of the front-ordered lane and a word
// of the back-ordered lane. Depends on deq_pkg.
`default_nettype none

module deq_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  wire                        i_clk,
    input  deq_pkg::t_cell_ctrl        i_ctrl,
    input  wire  [CNT_W-1:0]           i_cnt,
    input  wire  [deq_pkg::WORD_W-1:0] i_push_value,
    input  wire  [deq_pkg::WORD_W-1:0] i_f_left,
    input  wire  [deq_pkg::WORD_W-1:0] i_f_right,
    input  wire  [deq_pkg::WORD_W-1:0] i_b_left,
    input  wire  [deq_pkg::WORD_W-1:0] i_b_right,
    output logic [deq_pkg::WORD_W-1:0] o_f_word,
    output logic [deq_pkg::WORD_W-1:0] o_b_word
);
    import deq_pkg::*;

    logic [WORD_W-1:0] r_f;
    logic [WORD_W-1:0] n_f;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] n_b;
    logic              at_cnt;

    // This cell is the first free place of a lane when its index equals the count.
    assign at_cnt = (i_cnt == CNT_W'(IDX));

    always_comb begin
        n_f = r_f;
        if (i_ctrl.f_shr) begin
            n_f = i_f_left;
        end else if (i_ctrl.f_shl) begin
            n_f = i_f_right;
        end else if (i_ctrl.f_wr && at_cnt) begin
            n_f = i_push_value;
        end
    end

    always_comb begin
        n_b = r_b;
        if (i_ctrl.b_shr) begin
            n_b = i_b_left;
        end else if (i_ctrl.b_shl) begin
            n_b = i_b_right;
        end else if (i_ctrl.b_wr && at_cnt) begin
            n_b = i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
        r_b <= n_b;
    end

    assign o_f_word = r_f;
    assign o_b_word = r_b;

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// Double-ended queue of DEPTH signed 32-bit words built as a row of cells.
// It takes one operation word per clock while ready and shows its result word
// in the next cycle from an output register; a new operation is taken while
// that result waits as long as the downstream side takes it in the same
// cycle. The speed is set by the cell row: every cell shifts or loads, and
// the front and back words are always in cell 0 of their lane, so no search
// is needed. No clearing pass follows reset. Depends on deq_pkg and deq_cell.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // push_value
    input  wire  [deq_pkg::WORD_W-1:0]       i_s_tdata,
    // action
    input  wire  [deq_pkg::ACTION_W-1:0]     i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // popped_value, underflow, overflow, front_value, back_value,
    // entry_count, is_empty
    output logic [deq_pkg::RESULT_PAD_W-1:0] o_m_tdata
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_m_valid;
    logic [RESULT_PAD_W-1:0] r_m_data;

    logic [WORD_W-1:0] f_word [DEPTH];
    logic [WORD_W-1:0] b_word [DEPTH];

    t_action           action;
    t_cell_ctrl        ctrl;
    logic              accept;
    logic              empty;
    logic              full;
    logic              under;
    logic              over;
    logic [WORD_W-1:0] popped;
    logic [WORD_W-1:0] front_raw;
    logic [WORD_W-1:0] back_raw;
    logic [WORD_W-1:0] front_w;
    logic [WORD_W-1:0] back_w;

    assign action     = t_action'(i_s_tuser);
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign empty      = (r_cnt == '0);
    assign full       = (r_cnt == CNT_W'(DEPTH));

    // Operation decode: cell commands, flags and the words seen after the step.
    always_comb begin
        ctrl      = '0;
        under     = 1'b0;
        over      = 1'b0;
        popped    = EMPTY_WORD;
        n_cnt     = r_cnt;
        front_raw = f_word[0];
        back_raw  = b_word[0];
        unique case (action)
            ACT_PUSH_BACK: begin
                over = full;
                if (!full) begin
                    ctrl.f_wr = accept;
                    ctrl.b_shr = accept;
                    n_cnt = r_cnt + 1'b1;
                    back_raw = i_s_tdata;
                    if (empty) begin
                        front_raw = i_s_tdata;
                    end
                end
            end
            ACT_PUSH_FRONT: begin
                over = full;
                if (!full) begin
                    ctrl.f_shr = accept;
                    ctrl.b_wr = accept;
                    n_cnt = r_cnt + 1'b1;
                    front_raw = i_s_tdata;
                    if (empty) begin
                        back_raw = i_s_tdata;
                    end
                end
            end
            ACT_POP_BACK: begin
                under = empty;
                if (!empty) begin
                    ctrl.b_shl = accept;
                    n_cnt = r_cnt - 1'b1;
                    popped = b_word[0];
                    back_raw = b_word[1];
                end
            end
            ACT_POP_FRONT: begin
                under = empty;
                if (!empty) begin
                    ctrl.f_shl = accept;
                    n_cnt = r_cnt - 1'b1;
                    popped = f_word[0];
                    front_raw = f_word[1];
                end
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    assign front_w = (n_cnt == '0) ? EMPTY_WORD : front_raw;
    assign back_w  = (n_cnt == '0) ? EMPTY_WORD : back_raw;

    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [WORD_W-1:0] f_left;
            logic [WORD_W-1:0] f_right;
            logic [WORD_W-1:0] b_left;
            logic [WORD_W-1:0] b_right;

            // The push word enters at cell 0; the far end takes any word
            // since a shift toward cell 0 leaves that place unoccupied.
            if (gi == 0) begin : g_first
                assign f_left = i_s_tdata;
                assign b_left = i_s_tdata;
            end else begin : g_inner_l
                assign f_left = f_word[gi-1];
                assign b_left = b_word[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign f_right = i_s_tdata;
                assign b_right = i_s_tdata;
            end else begin : g_inner_r
                assign f_right = f_word[gi+1];
                assign b_right = b_word[gi+1];
            end

            deq_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_cnt        (r_cnt),
                .i_push_value (i_s_tdata),
                .i_f_left     (f_left),
                .i_f_right    (f_right),
                .i_b_left     (b_left),
                .i_b_right    (b_right),
                .o_f_word     (f_word[gi]),
                .o_b_word     (b_word[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt     <= n_cnt;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_data <= RESULT_PAD_W'({(n_cnt == '0), CNT_OUT_W'(n_cnt), back_w, front_w,
                                       over, under, popped});
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

// ----- rtl/deq_checker.sv -----
// Port-level checks of the double-ended queue, bound to its top level.
// Depends on deq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module deq_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    input  wire                              i_s_tready,
    input  wire  [deq_pkg::WORD_W-1:0]       i_s_tdata,
    input  wire  [deq_pkg::ACTION_W-1:0]     i_s_tuser,
    input  wire                              i_m_tvalid,
    input  wire                              i_m_tready,
    input  wire  [deq_pkg::RESULT_PAD_W-1:0] i_m_tdata
);
    import deq_pkg::*;

    logic              under;
    logic              over;
    logic              empty;
    logic [WORD_W-1:0] front_w;
    logic [WORD_W-1:0] back_w;
    logic [CNT_OUT_W-1:0] count;
    logic              s_busy;

    assign under   = i_m_tdata[WORD_W];
    assign over    = i_m_tdata[WORD_W+1];
    assign front_w = i_m_tdata[2*WORD_W+1:WORD_W+2];
    assign back_w  = i_m_tdata[3*WORD_W+1:2*WORD_W+2];
    assign count   = i_m_tdata[3*WORD_W+1+CNT_OUT_W:3*WORD_W+2];
    assign empty   = i_m_tdata[RESULT_W-1];
    // Input side is only observed, never driven; keep all its lines in use.
    assign s_busy  = i_s_tvalid && i_s_tready && (i_s_tdata == i_s_tdata)
                     && (i_s_tuser == i_s_tuser);

    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, i_m_tvalid && !i_m_tready,
                 i_m_tvalid && $stable(i_m_tdata))
    `ASSERT_SAME(a_flags_exclusive, i_clk, i_rst_n, i_m_tvalid, !(under && over))
    `ASSERT_SAME(a_empty_count, i_clk, i_rst_n, i_m_tvalid && empty, count == '0)
    `ASSERT_SAME(a_empty_ends, i_clk, i_rst_n, i_m_tvalid && empty,
                 front_w == EMPTY_WORD && back_w == EMPTY_WORD)
    `ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, s_busy, i_m_tvalid)

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

`default_nettype wire
